// File: rtl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg - shared types and constants for the varint stream decoder
// Status codes, field widths and the per-byte result record passed from
// the decode step to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vsd_pkg;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 32;
    localparam int CNT_W    = 4;   // holds a byte count up to 9 within a varint
    localparam int SHAMT_W  = 7;   // shift amount up to 63

    // Byte format
    localparam logic [BYTE_W-2:0] PAYLOAD_MASK  = 7'h7f;
    localparam int                CONT_BIT      = 7;
    localparam int                BITS_PER_BYTE = 7;
    localparam logic [CNT_W-1:0]  LAST_BYTE_IDX = 4'd9;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EOF      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_LIMIT    = 3'd4
    } status_t;

    // Result of one decode step
    typedef struct packed {
        logic                emit;
        status_t             status;
        logic [VALUE_W-1:0]  value;
    } step_res_t;

endpackage

`default_nettype wire

// File: rtl/varint_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit - unsigned LEB128 varint stream decoder
// Decodes up to 64-bit varints from a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one stream byte per transaction, or s_stream_end = 1 to mark
//   the end of data (byte ignored). A byte with bit 7 clear ends a varint.
//   m_* channel: one transaction per finished varint or error, carrying the
//   value (0 on error), a status code and the stream offset of the first byte.
//   cfg_* channel: writes the value limit; always ready, write only while idle.
// Output: the result is registered and is on m_* in the cycle after the byte that ends it.
// Throughput: one input transaction per cycle while m_* is not stalled; the
//   decode of a byte is a 7*k shift, an OR and a 64-bit compare against the
//   value limit, between the state registers and the output register.
// Stall: while an output transaction waits and m_ready is low, s_ready is
//   low; with the output register empty s_ready is high.
// Reset (aresetn low, synchronous): no varint pending, offset counter at 0,
//   output empty, value limit all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_stream_decoder_unit #(
    parameter int MAX_VARINT_BYTES = 10,
    parameter int POSITION_WIDTH   = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [vsd_pkg::VALUE_W-1:0]  cfg_data,
    // input stream
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [vsd_pkg::BYTE_W-1:0]   s_in_byte,
    input  wire logic                         s_stream_end,
    // results
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [vsd_pkg::VALUE_W-1:0]  m_decoded_value,
    output      logic [2:0]                   m_status,
    output      logic [vsd_pkg::OFFSET_W-1:0] m_start_offset
);
    import vsd_pkg::*;

    logic [VALUE_W-1:0]        limit_reg;
    logic [VALUE_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_cur;
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic                      out_valid_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    status_t                   out_status_reg;
    logic [OFFSET_W-1:0]       out_offset_reg;
    logic                      s_accept;
    step_res_t                 res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    // Decode step
    vsd_step #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_step (
        .in_byte    (s_in_byte),
        .stream_end (s_stream_end),
        .acc        (acc_reg),
        .cnt        (cnt_reg),
        .value_limit(limit_reg),
        .acc_next   (acc_next),
        .cnt_next   (cnt_next),
        .res        (res)
    );

    // First byte of a varint latches its own position
    assign start_cur = (!s_stream_end && cnt_reg == '0) ? pos_reg : start_reg;

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '1;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
        end else if (s_accept) begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_cur;
            if (!s_stream_end) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && res.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res.emit) begin
            out_value_reg  <= res.value;
            out_status_reg <= res.status;
            out_offset_reg <= OFFSET_W'(start_cur);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_decoded_value = out_value_reg;
    assign m_status        = out_status_reg;
    assign m_start_offset  = out_offset_reg;

endmodule

`default_nettype wire

// File: rtl/vsd_step.sv
// ----------------------------------------------------------------------------
// vsd_step - combinational decode of one stream byte
// Folds the byte's payload into the accumulator, checks the error cases
// and produces the next accumulator/count and an optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_step #(
    parameter int MAX_VARINT_BYTES = 10
) (
    input  wire logic [vsd_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic                        stream_end,
    input  wire logic [vsd_pkg::VALUE_W-1:0] acc,
    input  wire logic [vsd_pkg::CNT_W-1:0]   cnt,
    input  wire logic [vsd_pkg::VALUE_W-1:0] value_limit,
    output      logic [vsd_pkg::VALUE_W-1:0] acc_next,
    output      logic [vsd_pkg::CNT_W-1:0]   cnt_next,
    output      vsd_pkg::step_res_t          res
);
    import vsd_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VARINT_BYTES);

    logic [BYTE_W-2:0]  payload;
    logic [SHAMT_W-1:0] shamt;
    logic [VALUE_W-1:0] acc_or;
    logic [CNT_W-1:0]   cnt_inc;

    // Payload placed at bit 7*k
    assign payload = in_byte[BYTE_W-2:0] & PAYLOAD_MASK;
    assign shamt   = SHAMT_W'(cnt) * SHAMT_W'(BITS_PER_BYTE);
    assign acc_or  = (cnt <= LAST_BYTE_IDX) ? (acc | (VALUE_W'(payload) << shamt)) : acc;
    assign cnt_inc = cnt + 1'b1;

    // Next state and result
    always_comb begin
        acc_next   = acc;
        cnt_next   = cnt;
        res.emit   = 1'b0;
        res.status = ST_OK;
        res.value  = '0;
        if (stream_end) begin
            if (cnt != '0) begin
                res.emit   = 1'b1;
                res.status = ST_EOF;
            end
        end else if (cnt >= LAST_BYTE_IDX && payload > 7'd1) begin
            res.emit   = 1'b1;
            res.status = ST_OVERFLOW;
        end else if (!in_byte[CONT_BIT]) begin
            res.emit = 1'b1;
            if (acc_or > value_limit) begin
                res.status = ST_LIMIT;
            end else begin
                res.value = acc_or;
            end
        end else if (cnt_inc >= MAX_CNT) begin
            res.emit   = 1'b1;
            res.status = ST_TOO_MANY;
        end else begin
            acc_next = acc_or;
            cnt_next = cnt_inc;
        end
        // any result restarts decoding
        if (res.emit) begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/vsd_checker.sv
// ----------------------------------------------------------------------------
// vsd_checker - port-level checks for the varint stream decoder
// Watches the top-level ports; attached by the bind statement below.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [vsd_pkg::VALUE_W-1:0]  m_decoded_value,
    input wire logic [2:0]                   m_status,
    input wire logic [vsd_pkg::OFFSET_W-1:0] m_start_offset
);
    import vsd_pkg::*;

    // Output empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_decoded_value)
            && $stable(m_status) && $stable(m_start_offset))
        else $error("stalled result changed");

    // Input is held off while a result is stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("s_ready high while output stalled");

    // Error results carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_decoded_value == '0)
        else $error("nonzero value on error result");

    // Status is a defined code
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_EOF
            || m_status == ST_OVERFLOW || m_status == ST_TOO_MANY
            || m_status == ST_LIMIT)
        else $error("undefined status code");

endmodule

bind varint_stream_decoder_unit vsd_checker u_vsd_checker (.*);

`default_nettype wire

// File: dv/tb_varint_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_varint_stream_decoder_unit - self-checking bench for the varint decoder
// Streams bytes and end markers into the decoder. A scoreboard class tracks
// the decode state and the value limit, predicts every result and compares
// the results field by field. The limit is changed between phases while the
// decoder is idle. Both sides idle at random, and there is one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_varint_stream_decoder_unit;
    import vsd_pkg::*;

    localparam int MAX_BYTES      = 10;
    localparam int PHASE_BYTES    = 275;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int NUM_PHASES     = 7;

    // Expected result record
    typedef struct {
        logic [VALUE_W-1:0]  value;
        status_t             status;
        logic [OFFSET_W-1:0] offset;
    } varint_result_t;

    // Scoreboard: tracks the decode state, predicts results and checks them
    class varint_scoreboard;
        logic [VALUE_W-1:0]  limit = '1;
        logic [VALUE_W-1:0]  acc = '0;
        logic [CNT_W-1:0]    nbytes = '0;
        logic [OFFSET_W-1:0] vstart = '0;
        logic [OFFSET_W-1:0] bpos = '0;
        varint_result_t      expected_q[$];
        int                  errors = 0;

        function void set_limit(logic [VALUE_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit varint_open();
            return nbytes != 0;
        endfunction

        // Queue one result and start the next varint fresh
        function void close_varint(logic [VALUE_W-1:0] v, status_t st);
            varint_result_t r;
            r.value  = v;
            r.status = st;
            r.offset = vstart;
            expected_q.push_back(r);
            acc    = '0;
            nbytes = '0;
        endfunction

        // Accepted input transaction: advance the decode state
        function void note_input(logic [BYTE_W-1:0] b, logic at_end);
            logic [BYTE_W-2:0] pay;
            if (at_end) begin
                if (nbytes != 0)
                    close_varint('0, ST_EOF);
                return;
            end
            if (nbytes == 0)
                vstart = bpos;
            bpos = bpos + 1'b1;
            pay  = b[BYTE_W-2:0] & PAYLOAD_MASK;
            // tenth byte may only carry bit 63
            if (nbytes >= LAST_BYTE_IDX && pay > 1) begin
                close_varint('0, ST_OVERFLOW);
                return;
            end
            if (nbytes <= LAST_BYTE_IDX)
                acc |= {{(VALUE_W-BYTE_W+1){1'b0}}, pay} << (BITS_PER_BYTE * nbytes);
            nbytes = nbytes + 1'b1;
            if (!b[CONT_BIT]) begin
                if (acc > limit)
                    close_varint('0, ST_LIMIT);
                else
                    close_varint(acc, ST_OK);
                return;
            end
            if (nbytes >= MAX_BYTES)
                close_varint('0, ST_TOO_MANY);
        endfunction

        // Accepted result transaction: compare with the oldest expectation
        function void check_result(logic [VALUE_W-1:0] v, logic [2:0] st,
                                   logic [OFFSET_W-1:0] off);
            varint_result_t r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: value=%0h status=%0d start_offset=%0d",
                       v, st, off);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (v !== r.value) begin
                $error("decoded_value: expected %0h, actual %0h", r.value, v);
                errors++;
            end
            if (st !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (off !== r.offset) begin
                $error("start_offset: expected %0d, actual %0d", r.offset, off);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VALUE_W-1:0]  cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_in_byte = '0;
    logic                s_stream_end = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [VALUE_W-1:0]  m_decoded_value;
    logic [2:0]          m_status;
    logic [OFFSET_W-1:0] m_start_offset;

    varint_scoreboard    sb = new();
    logic [VALUE_W-1:0]  cur_limit = '1;
    bit                  no_idle = 1'b0;
    bit                  rx_hold_req = 1'b0;
    int                  stall_cycles = 0;

    varint_stream_decoder_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_stream_end    (s_stream_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decoded_value (m_decoded_value),
        .m_status        (m_status),
        .m_start_offset  (m_start_offset)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor: every transaction is seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_decoded_value, m_status, m_start_offset);
            if (s_valid && s_ready)
                sb.note_input(s_in_byte, s_stream_end);
            if (cfg_valid && cfg_ready)
                sb.set_limit(cfg_data);
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready = no_idle || ($urandom_range(0, 99) >= 14);
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic at_end);
        while (!no_idle && $urandom_range(0, 99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_in_byte    = b;
        s_stream_end = at_end;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Continuation bytes with random payload
    task automatic send_cont_bytes(input int count);
        repeat (count) send_item({1'b1, 7'($urandom)}, 1'b0);
    endtask

    // Encode one value, optionally padded with zero continuation bytes
    task automatic send_varint(input logic [VALUE_W-1:0] v, input int pad, output int n);
        int groups;
        int total;
        logic [BYTE_W-2:0] pay;
        groups = 1;
        while (groups < MAX_BYTES && (v >> (BITS_PER_BYTE * groups)) != 0)
            groups++;
        total = groups + pad;
        if (total > MAX_BYTES)
            total = MAX_BYTES;
        for (int i = 0; i < total; i++) begin
            pay = (i < groups) ? 7'(v >> (BITS_PER_BYTE * i)) : 7'd0;
            send_item({i < total - 1, pay}, 1'b0);
        end
        n = total;
    endtask

    // Mostly well-formed varints, the rest errors, truncations and noise
    task automatic send_random_sequence(output int n);
        int kind;
        int k;
        logic [VALUE_W-1:0] v;
        kind = $urandom_range(0, 99);
        n = 0;
        if (kind < 55) begin
            case ($urandom_range(0, 19))
                0:       v = '1;
                1:       v = '0;
                2:       v = cur_limit;
                3:       v = cur_limit + 1'b1;
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
            send_varint(v, k, n);
        end else if (kind < 63) begin
            // payload beyond bit 63 on the tenth byte, either top bit
            send_cont_bytes(MAX_BYTES - 1);
            send_item({$urandom_range(0, 1) == 1, 7'($urandom_range(2, 127))}, 1'b0);
            n = MAX_BYTES;
        end else if (kind < 71) begin
            // ten bytes all continuing, tenth payload still in range
            send_cont_bytes(MAX_BYTES - 1);
            send_item({1'b1, 6'd0, $urandom_range(0, 1) == 1}, 1'b0);
            n = MAX_BYTES;
        end else if (kind < 81) begin
            // data ends mid-varint
            n = $urandom_range(1, MAX_BYTES - 1);
            send_cont_bytes(n);
            send_item(8'($urandom), 1'b1);
        end else if (kind < 86) begin
            // end marker with nothing pending
            if (!sb.varint_open())
                send_item(8'($urandom), 1'b1);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(8'($urandom), 1'b0);
        end
    endtask

    // Close any open varint, then wait for every expected result
    task automatic settle_decoder();
        if (sb.varint_open())
            send_item(8'($urandom), 1'b1);
        s_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Limit register write, only while the decoder is idle
    task automatic write_limit(input logic [VALUE_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        cur_limit = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [VALUE_W-1:0] phase_limit;
        int n;
        int sent;

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, end handling, full-width value, overflow
        send_item(8'h00, 1'b0);
        send_item(8'h7f, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b1);
        send_varint('1, 0, n);
        send_cont_bytes(MAX_BYTES - 1);
        send_item(8'h82, 1'b0);
        settle_decoder();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       phase_limit = '0;
                2:       phase_limit = '1;
                3:       phase_limit = 64'd127;
                5:       phase_limit = 64'h8000_0000_0000_0000;
                default: phase_limit = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            write_limit(phase_limit);
            rx_hold_req = (p == 1);
            no_idle     = (p == 2);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                send_random_sequence(n);
                sent += n;
            end
            settle_decoder();
            no_idle = 1'b0;
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
